[design/dfo_pkg.sv]
// Package for the dispersive flies optimiser core: sizes, command codes,
// state encoding and the generator control bundle. No dependencies.
package dfo_pkg;

    localparam int MAX_FLIES  = 64;
    localparam int MAX_COEFFS = 16;
    localparam int COORD_W    = 16;
    localparam int FLY_W      = 6;
    localparam int CO_W       = 4;
    localparam int POS_AW     = FLY_W + CO_W;
    localparam int POS_DEPTH  = MAX_FLIES * MAX_COEFFS;
    localparam int DIST_W     = 38;
    localparam int MUL_W      = COORD_W + 1;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [1:0] CMD_LOAD_TARGET = 2'd0;
    localparam logic [1:0] CMD_LOAD_FLY    = 2'd1;
    localparam logic [1:0] CMD_SCATTER     = 2'd2;
    localparam logic [1:0] CMD_RUN         = 2'd3;

    localparam logic [2:0] REG_NUM_FLIES  = 3'd0;
    localparam logic [2:0] REG_NUM_COEFFS = 3'd1;
    localparam logic [2:0] REG_ITERATIONS = 3'd2;
    localparam logic [2:0] REG_LOWER      = 3'd3;
    localparam logic [2:0] REG_UPPER      = 3'd4;
    localparam logic [2:0] REG_THRESHOLD  = 3'd5;
    localparam logic [2:0] REG_SEED       = 3'd6;

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_SC_DRAW = 20'h00002,
        ST_SC_MUL  = 20'h00004,
        ST_SC_WR   = 20'h00008,
        ST_D_RD    = 20'h00010,
        ST_D_MUL   = 20'h00020,
        ST_D_ACC   = 20'h00040,
        ST_F_RD    = 20'h00080,
        ST_F_CMP   = 20'h00100,
        ST_U_START = 20'h00200,
        ST_U_L     = 20'h00400,
        ST_U_R     = 20'h00800,
        ST_U_DEC   = 20'h01000,
        ST_M_RDB   = 20'h02000,
        ST_M_RDF   = 20'h04000,
        ST_M_MUL   = 20'h08000,
        ST_M_WR    = 20'h10000,
        ST_E_RD    = 20'h20000,
        ST_E_LD    = 20'h40000,
        ST_E_HOLD  = 20'h80000
    } state_t;

    typedef struct packed {
        logic        step;
        logic        load;
        logic [31:0] seed;
    } rng_ctrl_t;

endpackage

[design/dispersive_flies_optimizer_core.sv]
// Top level of the dispersive flies optimiser: sequencer, registers and memories.
// Depends on dfo_pkg, dfo_ram, dfo_rng and dfo_mul.
//
// channel | dir | handshake          | contents
// s_      | in  | s_tvalid/s_tready  | command word
// m_      | out | m_tvalid/m_tready  | best fly coordinate word
// cfg_    | in  | cfg_valid/cfg_ready| register index and data
//
// Loads are taken and written in idle. A scatter draws, multiplies and writes each
// coordinate of every fly. A run scores every fly and then updates each fly but
// the best each iteration, paced by the single multiplier and the single read
// port of the position memory; then it emits one word per best-fly coordinate.
// Reset is synchronous; no memory is cleared. The input stalls until a
// command is complete, and emission waits on m_tready.
module dispersive_flies_optimizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // fly_index, coeff_index, in_value
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // best_fly, out_coeff_index, out_value
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import dfo_pkg::*;

    state_t state_reg, state_next;
    logic [FLY_W-1:0] i_reg, i_next, fit_reg, fit_next, nb_reg, nb_next;
    logic [CO_W-1:0] j_reg, j_next;
    logic [15:0] it_reg, it_next;
    logic [DIST_W-1:0] acc_reg, acc_next, bestd_reg, bestd_next, dl_reg, dl_next;
    logic [COORD_W-1:0] base_reg, base_next, out_reg, out_next;
    logic scat_run_reg, scat_run_next, mv_reg, mv_next;
    logic signed [MUL_W-1:0] span_reg, span_next;
    logic [6:0] nfl_reg;
    logic [4:0] nco_reg;
    logic [15:0] iter_reg, lo_reg, hi_reg, thr_reg;

    logic [FLY_W-1:0] nf_m1, left, right;
    logic [CO_W-1:0] nc_m1;
    logic [6:0] nf_sat;
    logic [4:0] nc_sat;

    logic pos_we, tgt_we, dist_we;
    logic [POS_AW-1:0] pos_waddr, pos_raddr;
    logic [COORD_W-1:0] pos_wdata, pos_rdata, tgt_rdata;
    logic [DIST_W-1:0] dist_wdata, dist_rdata;
    logic [FLY_W-1:0] dist_raddr;
    logic signed [MUL_W-1:0] mul_a, mul_b, diff;
    logic signed [PROD_W-1:0] prod;
    rng_ctrl_t rng_ctrl;
    logic [31:0] rng_word;
    logic s_acc;
    logic [FLY_W-1:0] in_fly;
    logic [CO_W-1:0] in_co;
    logic [COORD_W-1:0] in_val;
    logic signed [MUL_W-1:0] lo_x, hi_x;

    assign in_fly = s_tdata[5:0];
    assign in_co  = s_tdata[9:6];
    assign in_val = s_tdata[25:10];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign nf_sat = (nfl_reg < 7'd3) ? 7'd3 : (nfl_reg > 7'(MAX_FLIES)) ? 7'(MAX_FLIES) : nfl_reg;
    assign nc_sat = (nco_reg < 5'd1) ? 5'd1 :
                    (nco_reg > 5'(MAX_COEFFS)) ? 5'(MAX_COEFFS) : nco_reg;
    assign nf_m1 = FLY_W'(nf_sat - 7'd1);
    assign nc_m1 = CO_W'(nc_sat - 5'd1);
    assign left  = (i_reg == '0) ? nf_m1 : i_reg - 1'b1;
    assign right = (i_reg == nf_m1) ? '0 : i_reg + 1'b1;
    assign lo_x = MUL_W'(signed'(lo_reg));
    assign hi_x = MUL_W'(signed'(hi_reg));

    dfo_ram #(.WIDTH(COORD_W), .DEPTH(POS_DEPTH)) u_pos (
        .aclk(aclk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata));
    dfo_ram #(.WIDTH(COORD_W), .DEPTH(MAX_COEFFS)) u_tgt (
        .aclk(aclk), .we(tgt_we), .waddr(in_co), .wdata(in_val),
        .raddr(j_reg), .rdata(tgt_rdata));
    dfo_ram #(.WIDTH(DIST_W), .DEPTH(MAX_FLIES)) u_dist (
        .aclk(aclk), .we(dist_we), .waddr(i_reg), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_rdata));
    dfo_rng u_rng (.aclk(aclk), .aresetn(aresetn), .ctrl(rng_ctrl), .word(rng_word));
    dfo_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(prod));

    always_comb begin
        case (state_reg)
            ST_M_RDB: pos_raddr = {nb_reg, j_reg};
            ST_M_RDF, ST_E_RD: pos_raddr = {fit_reg, j_reg};
            default:  pos_raddr = {i_reg, j_reg};
        endcase
        case (state_reg)
            ST_U_START: dist_raddr = left;
            ST_U_L:     dist_raddr = right;
            default:    dist_raddr = i_reg;
        endcase
        diff = (state_reg == ST_D_MUL)
             ? MUL_W'(signed'(tgt_rdata)) - MUL_W'(signed'(pos_rdata))
             : MUL_W'(signed'(pos_rdata)) - MUL_W'(signed'(base_reg));
        mul_a = (state_reg == ST_D_MUL) ? diff : {1'b0, rng_word[31:16]};
        mul_b = (state_reg == ST_SC_MUL) ? span_reg : diff;
    end

    always_comb begin
        state_next = state_reg; i_next = i_reg; j_next = j_reg; it_next = it_reg;
        acc_next = acc_reg; bestd_next = bestd_reg; fit_next = fit_reg; dl_next = dl_reg;
        nb_next = nb_reg; base_next = base_reg; out_next = out_reg;
        scat_run_next = scat_run_reg; mv_next = mv_reg; span_next = span_reg;
        pos_we = 1'b0; pos_waddr = {i_reg, j_reg}; pos_wdata = in_val;
        tgt_we = 1'b0; dist_we = 1'b0; dist_wdata = acc_reg + DIST_W'(prod[31:0]);
        rng_ctrl.step = 1'b0;
        rng_ctrl.load = cfg_valid && (cfg_index == REG_SEED);
        rng_ctrl.seed = cfg_data;

        case (state_reg)
            ST_IDLE: begin
                span_next = (hi_x >= lo_x) ? hi_x - lo_x : '0;
                if (s_acc) begin
                    case (s_tuser)
                        CMD_LOAD_TARGET: tgt_we = 1'b1;
                        CMD_LOAD_FLY: begin
                            pos_we = 1'b1;
                            pos_waddr = {in_fly, in_co};
                        end
                        CMD_SCATTER: begin
                            i_next = '0; j_next = '0; scat_run_next = 1'b0;
                            state_next = ST_SC_DRAW;
                        end
                        default: begin
                            i_next = '0; j_next = '0; it_next = '0; acc_next = '0;
                            state_next = (iter_reg == 16'd0) ? ST_E_RD : ST_D_RD;
                        end
                    endcase
                end
            end
            ST_SC_DRAW: begin
                rng_ctrl.step = 1'b1;
                state_next = ST_SC_MUL;
            end
            ST_SC_MUL: state_next = ST_SC_WR;
            ST_SC_WR: begin
                pos_we = 1'b1;
                pos_wdata = lo_reg + prod[31:16];
                j_next = j_reg + 1'b1;
                state_next = ST_SC_DRAW;
                if (j_reg == nc_m1) begin
                    j_next = '0;
                    if (scat_run_reg) begin
                        mv_next = 1'b1;
                        state_next = ST_U_START;
                    end else if (i_reg == nf_m1) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_D_RD: state_next = ST_D_MUL;
            ST_D_MUL: state_next = ST_D_ACC;
            ST_D_ACC: begin
                acc_next = acc_reg + DIST_W'(prod[31:0]);
                j_next = j_reg + 1'b1;
                state_next = ST_D_RD;
                if (j_reg == nc_m1) begin
                    dist_we = 1'b1;
                    acc_next = '0;
                    j_next = '0;
                    if (i_reg == nf_m1) begin
                        i_next = '0;
                        state_next = ST_F_RD;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_F_RD: state_next = ST_F_CMP;
            ST_F_CMP: begin
                if (i_reg == '0 || dist_rdata < bestd_reg) begin
                    bestd_next = dist_rdata;
                    fit_next = i_reg;
                end
                i_next = i_reg + 1'b1;
                state_next = ST_F_RD;
                if (i_reg == nf_m1) begin
                    i_next = '0;
                    mv_next = 1'b0;
                    state_next = ST_U_START;
                end
            end
            ST_U_START: begin
                // mv_reg marks that fly i has been updated and the sweep moves on.
                if (mv_reg || i_reg == fit_reg) begin
                    mv_next = 1'b0;
                    j_next = '0;
                    if (i_reg == nf_m1) begin
                        i_next = '0;
                        if (it_reg == iter_reg - 16'd1) begin
                            state_next = ST_E_RD;
                        end else begin
                            it_next = it_reg + 16'd1;
                            acc_next = '0;
                            state_next = ST_D_RD;
                        end
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_U_L;
                end
            end
            ST_U_L: begin
                dl_next = dist_rdata;
                state_next = ST_U_R;
            end
            ST_U_R: begin
                if (dl_reg < dist_rdata) begin
                    nb_next = left;
                end else if (dl_reg > dist_rdata) begin
                    nb_next = right;
                end else begin
                    nb_next = '0;
                end
                rng_ctrl.step = 1'b1;
                state_next = ST_U_DEC;
            end
            ST_U_DEC: begin
                j_next = '0;
                if (rng_word[31:16] < thr_reg) begin
                    scat_run_next = 1'b1;
                    state_next = ST_SC_DRAW;
                end else begin
                    state_next = ST_M_RDB;
                end
            end
            ST_M_RDB: state_next = ST_M_RDF;
            ST_M_RDF: begin
                base_next = pos_rdata;
                rng_ctrl.step = 1'b1;
                state_next = ST_M_MUL;
            end
            ST_M_MUL: state_next = ST_M_WR;
            ST_M_WR: begin
                pos_we = 1'b1;
                pos_wdata = base_reg + prod[31:16];
                j_next = j_reg + 1'b1;
                state_next = ST_M_RDB;
                if (j_reg == nc_m1) begin
                    j_next = '0;
                    mv_next = 1'b1;
                    state_next = ST_U_START;
                end
            end
            ST_E_RD: state_next = ST_E_LD;
            ST_E_LD: begin
                out_next = pos_rdata;
                state_next = ST_E_HOLD;
            end
            ST_E_HOLD: begin
                if (m_tready) begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_E_RD;
                    if (j_reg == nc_m1) begin
                        j_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fit_reg <= '0;
            scat_run_reg <= 1'b0;
            mv_reg <= 1'b0;
            nfl_reg <= 7'd64;
            nco_reg <= 5'd13;
            iter_reg <= 16'd100;
            lo_reg <= 16'hE000;
            hi_reg <= 16'h2000;
            thr_reg <= 16'd6554;
        end else begin
            state_reg <= state_next;
            fit_reg <= fit_next;
            scat_run_reg <= scat_run_next;
            mv_reg <= mv_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_NUM_FLIES:  nfl_reg <= cfg_data[6:0];
                    REG_NUM_COEFFS: nco_reg <= cfg_data[4:0];
                    REG_ITERATIONS: iter_reg <= cfg_data[15:0];
                    REG_LOWER:      lo_reg <= cfg_data[15:0];
                    REG_UPPER:      hi_reg <= cfg_data[15:0];
                    REG_THRESHOLD:  thr_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next; j_reg <= j_next; it_reg <= it_next; acc_reg <= acc_next;
        bestd_reg <= bestd_next; dl_reg <= dl_next; nb_reg <= nb_next;
        base_reg <= base_next; out_reg <= out_next; span_reg <= span_next;
    end

    assign m_tvalid = (state_reg == ST_E_HOLD);
    assign m_tlast  = (j_reg == nc_m1);
    assign m_tdata  = {6'd0, out_reg, j_reg, fit_reg};

    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input taken while a word is shown");
    a_nb_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_RDB) |-> nb_reg <= nf_m1) else $error("neighbour outside ring");
    a_fit_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_U_DEC) |-> (i_reg != fit_reg && fit_reg <= nf_m1))
        else $error("best fly selected for update");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_reg) && $stable(j_reg)))
        else $error("result word changed while stalled");
endmodule

[design/dfo_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module dfo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/dfo_rng.sv]
// Xorshift32 generator for the optimiser core, stepped once per draw.
// Depends on dfo_pkg.
module dfo_rng (
    input  logic              aclk,
    input  logic              aresetn,
    input  dfo_pkg::rng_ctrl_t ctrl,
    output logic [31:0]       word
);
    import dfo_pkg::*;

    logic [31:0] word_reg, word_next, x1, x2;

    always_comb begin
        x1 = word_reg ^ (word_reg << 13);
        x2 = x1 ^ (x1 >> 17);
        word_next = word_reg;
        if (ctrl.load) begin
            word_next = (ctrl.seed == 32'd0) ? 32'd1 : ctrl.seed;
        end else if (ctrl.step) begin
            word_next = x2 ^ (x2 << 5);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= 32'd1;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn) word_reg != 32'd0)
        else $error("generator word is zero");
endmodule

[design/dfo_mul.sv]
// Shared signed multiplier of the optimiser core with a registered product.
// Depends on dfo_pkg.
module dfo_mul (
    input  logic                               aclk,
    input  logic signed [dfo_pkg::MUL_W-1:0]   a,
    input  logic signed [dfo_pkg::MUL_W-1:0]   b,
    output logic signed [dfo_pkg::PROD_W-1:0]  p
);
    import dfo_pkg::*;

    always_ff @(posedge aclk) begin
        p <= a * b;
    end
endmodule

[tb/tb_dispersive_flies_optimizer_core.sv]
// Self-checking testbench for dispersive_flies_optimizer_core: drives command
// words and register writes, predicts every best-fly word and checks the output.
// Depends on dfo_pkg and the core RTL.
module tb_dispersive_flies_optimizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dfo_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int SETTLE      = 3 * MAX_FLIES * MAX_COEFFS + 64;

    typedef struct {
        logic [1:0]         cmd;
        logic [FLY_W-1:0]   fly;
        logic [CO_W-1:0]    coeff;
        logic [COORD_W-1:0] value;
    } command_t;

    typedef struct {
        logic [FLY_W-1:0]   fly;
        logic [CO_W-1:0]    coeff;
        logic [COORD_W-1:0] value;
        logic               last;
    } coord_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    dispersive_flies_optimizer_core dut (.*);

    always #5 aclk = ~aclk;

    // Shadow of the swarm
    logic signed [COORD_W-1:0] swarm_pos [MAX_FLIES][MAX_COEFFS];
    logic signed [COORD_W-1:0] target_pos [MAX_COEFFS];
    longint unsigned           fly_score [MAX_FLIES];
    logic [31:0]               rng_state;
    int                        best_idx;
    logic [6:0]                sh_flies;
    logic [4:0]                sh_coeffs;
    logic [15:0]               sh_iters, sh_lower, sh_upper, sh_thresh;

    command_t    cmd_q [$];
    coord_word_t coord_q [$];
    command_t    on_bus;
    logic        s_fire = 1'b0;
    int          gap_left = 0, stall_left = 0, hold_left = 0;
    bit          hold_req = 0, hold_done = 0, calm = 0;
    int          err_count = 0;
    int          cycles = 0;

    function automatic longint frac_draw();
        rng_state ^= rng_state << 13;
        rng_state ^= rng_state >> 17;
        rng_state ^= rng_state << 5;
        return longint'(rng_state[31:16]);
    endfunction

    function automatic logic [COORD_W-1:0] scatter_coord();
        longint lo, hi, span, r, v;
        lo = longint'($signed(sh_lower));
        hi = longint'($signed(sh_upper));
        span = (hi >= lo) ? hi - lo : 0;
        r = frac_draw();
        v = lo + ((r * span) >>> 16);
        return v[COORD_W-1:0];
    endfunction

    function automatic void swarm_iteration(int nf, int nc);
        longint d, base, diff, r, v;
        longint unsigned acc;
        int left, right, nb;
        for (int i = 0; i < nf; i++) begin
            acc = 0;
            for (int j = 0; j < nc; j++) begin
                d = longint'(target_pos[j]) - longint'(swarm_pos[i][j]);
                acc += longint'(d * d);
            end
            fly_score[i] = acc;
        end
        best_idx = 0;
        for (int i = 1; i < nf; i++)
            if (fly_score[i] < fly_score[best_idx]) best_idx = i;
        for (int i = 0; i < nf; i++) begin
            if (i == best_idx) continue;
            left = (i == 0) ? nf - 1 : i - 1;
            right = (i == nf - 1) ? 0 : i + 1;
            if (fly_score[left] < fly_score[right]) nb = left;
            else if (fly_score[left] > fly_score[right]) nb = right;
            else nb = 0;
            if (frac_draw() < longint'(sh_thresh)) begin
                for (int j = 0; j < nc; j++) swarm_pos[i][j] = scatter_coord();
            end else begin
                for (int j = 0; j < nc; j++) begin
                    base = longint'(swarm_pos[nb][j]);
                    diff = longint'(swarm_pos[best_idx][j]) - base;
                    r = frac_draw();
                    v = base + ((r * diff) >>> 16);
                    swarm_pos[i][j] = v[COORD_W-1:0];
                end
            end
        end
    endfunction

    function automatic void predict_command(command_t c);
        int nf, nc;
        coord_word_t w;
        nf = (sh_flies < 3) ? 3 : (sh_flies > MAX_FLIES) ? MAX_FLIES : int'(sh_flies);
        nc = (sh_coeffs < 1) ? 1 : (sh_coeffs > MAX_COEFFS) ? MAX_COEFFS : int'(sh_coeffs);
        case (c.cmd)
            CMD_LOAD_TARGET: target_pos[c.coeff] = c.value;
            CMD_LOAD_FLY:    swarm_pos[c.fly][c.coeff] = c.value;
            CMD_SCATTER: begin
                for (int i = 0; i < nf; i++)
                    for (int j = 0; j < nc; j++) swarm_pos[i][j] = scatter_coord();
            end
            default: begin
                for (int k = 0; k < int'(sh_iters); k++) swarm_iteration(nf, nc);
                for (int j = 0; j < nc; j++) begin
                    w.fly = best_idx[FLY_W-1:0];
                    w.coeff = j[CO_W-1:0];
                    w.value = swarm_pos[best_idx][j];
                    w.last = (j == nc - 1);
                    coord_q = {coord_q, w};
                end
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_dispersive_flies_optimizer_core: done, errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_fire) predict_command(on_bus);
            if (s_tvalid && !s_fire) begin
                s_tvalid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                on_bus = cmd_q.pop_front();
                s_tdata <= {6'd0, on_bus.value, on_bus.coeff, on_bus.fly};
                s_tuser <= on_bus.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 2500;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        coord_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (coord_q.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                err_count++;
            end else begin
                w = coord_q.pop_front();
                if (m_tdata[5:0] !== w.fly) begin
                    $error("best_fly: expected %0d, got %0d", w.fly, m_tdata[5:0]);
                    err_count++;
                end
                if (m_tdata[9:6] !== w.coeff) begin
                    $error("out_coeff_index: expected %0d, got %0d", w.coeff, m_tdata[9:6]);
                    err_count++;
                end
                if (m_tdata[25:10] !== w.value) begin
                    $error("out_value: expected %h, got %h", w.value, m_tdata[25:10]);
                    err_count++;
                end
                if (m_tlast !== w.last) begin
                    $error("last_flag: expected %0d, got %0d", w.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (cmd_q.size() > 0 || s_tvalid || coord_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_NUM_FLIES:  sh_flies = val[6:0];
            REG_NUM_COEFFS: sh_coeffs = val[4:0];
            REG_ITERATIONS: sh_iters = val[15:0];
            REG_LOWER:      sh_lower = val[15:0];
            REG_UPPER:      sh_upper = val[15:0];
            REG_THRESHOLD:  sh_thresh = val[15:0];
            REG_SEED:       rng_state = (val == 0) ? 32'd1 : val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(logic [1:0] c, int fi, int ci, logic [15:0] v);
        command_t x;
        x.cmd = c;
        x.fly = fi[FLY_W-1:0];
        x.coeff = ci[CO_W-1:0];
        x.value = v;
        cmd_q = {cmd_q, x};
    endtask

    task automatic push_random();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            push_cmd(CMD_LOAD_TARGET, $urandom_range(0, 63), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
        else if (sel < 65)
            push_cmd(CMD_LOAD_FLY, $urandom_range(0, 63), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
        else if (sel < 75)
            push_cmd(CMD_SCATTER, $urandom_range(0, 63), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
        else
            push_cmd(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
    endtask

    task automatic random_setup();
        logic [15:0] a, b;
        if ($urandom_range(0, 7) == 0) write_reg(REG_NUM_FLIES, $urandom_range(0, 127));
        else write_reg(REG_NUM_FLIES, $urandom_range(3, 12));
        if ($urandom_range(0, 7) == 0) write_reg(REG_NUM_COEFFS, $urandom_range(0, 31));
        else write_reg(REG_NUM_COEFFS, $urandom_range(1, 6));
        write_reg(REG_ITERATIONS, $urandom_range(1, 3));
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        if ($urandom_range(0, 5) != 0 && $signed(a) > $signed(b)) begin
            write_reg(REG_LOWER, b);
            write_reg(REG_UPPER, a);
        end else begin
            write_reg(REG_LOWER, a);
            write_reg(REG_UPPER, b);
        end
        write_reg(REG_THRESHOLD, $urandom_range(0, 65535));
        if ($urandom_range(0, 2) == 0) write_reg(REG_SEED, $urandom());
    endtask

    initial begin
        sh_flies = 7'd64;
        sh_coeffs = 5'd13;
        sh_iters = 16'd100;
        sh_lower = 16'hE000;
        sh_upper = 16'h2000;
        sh_thresh = 16'd6554;
        rng_state = 32'd1;
        best_idx = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full sizes first so that every target and position gets written.
        write_reg(REG_NUM_FLIES, 64);
        write_reg(REG_NUM_COEFFS, 16);
        write_reg(REG_ITERATIONS, 1);
        write_reg(REG_LOWER, 16'h8000);
        write_reg(REG_UPPER, 16'h7FFF);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_SEED, 0);
        for (int j = 0; j < MAX_COEFFS; j++)
            push_cmd(CMD_LOAD_TARGET, 0, j, (j % 2) ? 16'h7FFF : 16'h8000);
        push_cmd(CMD_SCATTER, 0, 0, 0);
        push_cmd(CMD_LOAD_FLY, 63, 15, 16'h7FFF);
        push_cmd(CMD_LOAD_FLY, 0, 0, 16'h8000);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle();

        // Saturated sizes, zero iterations, full disturbance.
        write_reg(REG_NUM_FLIES, 0);
        write_reg(REG_NUM_COEFFS, 0);
        write_reg(REG_ITERATIONS, 0);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle();
        write_reg(REG_NUM_FLIES, 127);
        write_reg(REG_NUM_COEFFS, 31);
        write_reg(REG_ITERATIONS, 1);
        write_reg(REG_THRESHOLD, 16'hFFFF);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle();

        // Inverted bounds, then equal bounds so every neighbour pair ties.
        write_reg(REG_NUM_FLIES, 5);
        write_reg(REG_NUM_COEFFS, 3);
        write_reg(REG_LOWER, 16'd100);
        write_reg(REG_UPPER, -16'sd100);
        push_cmd(CMD_SCATTER, 0, 0, 0);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle();
        write_reg(REG_LOWER, 16'd5);
        write_reg(REG_UPPER, 16'd5);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_ITERATIONS, 2);
        push_cmd(CMD_SCATTER, 0, 0, 0);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle();

        // Largest iteration count, exercised with loads only.
        write_reg(REG_ITERATIONS, 16'hFFFF);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        push_cmd(CMD_LOAD_FLY, 42, 9, 16'h1234);
        push_cmd(CMD_LOAD_TARGET, 0, 15, 16'h0000);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            random_setup();
            if (p == 3) begin
                hold_req = 1;
                for (int k = 0; k < 6; k++) push_cmd(CMD_RUN, 0, 0, 0);
            end
            if (p == 9) calm = 1;
            for (int k = 0; k < 30; k++) push_random();
            wait_idle();
        end

        if (err_count == 0) begin
            $display("tb_dispersive_flies_optimizer_core: done, clean");
        end else begin
            $display("tb_dispersive_flies_optimizer_core: done, errors");
        end
        $finish;
    end
endmodule
